[rtl/core/rflp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rflp_pkg
// shared types and constants of the rotated framebuffer line plotter
// ----------------------------------------------------------------------------
package rflp_pkg;

    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 296;
    localparam int CRD_W  = 9;
    localparam int ADDR_W = 13;
    localparam int CMD_W  = 2;

    typedef enum logic [1:0] {
        CMD_PLOT  = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // queued command, endpoints already ordered for the line walker
    typedef struct packed {
        t_cmd              cmd;
        logic              steep;
        logic [CRD_W-1:0]  x0;     // major start
        logic [CRD_W-1:0]  y0;     // minor start
        logic [CRD_W-1:0]  x1;     // major end
        logic              ydown;  // minor steps by -1
        logic [CRD_W-1:0]  dy;
        logic              ink;
        logic [ADDR_W-1:0] baddr;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_RD,
        ST_WR,
        ST_CLR,
        ST_RDATA,
        ST_OUT
    } t_state;

endpackage

[rtl/core/rflp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rflp_front
// accepts commands, orders line endpoints and keeps a two-entry queue
// ----------------------------------------------------------------------------
module rflp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rflp_pkg::CMD_W-1:0]     i_cmd,
    input  logic [rflp_pkg::CRD_W-1:0]     i_x_a,
    input  logic [rflp_pkg::CRD_W-1:0]     i_y_a,
    input  logic [rflp_pkg::CRD_W-1:0]     i_x_b,
    input  logic [rflp_pkg::CRD_W-1:0]     i_y_b,
    input  logic                           i_ink,
    input  logic [rflp_pkg::ADDR_W-1:0]    i_byte_addr,
    output logic                           o_job_valid,
    input  logic                           i_job_ready,
    output rflp_pkg::t_job                 o_job
);
    import rflp_pkg::*;

    logic [CRD_W-1:0] adx, ady, ax0, ay0, ax1, ay1;
    logic             steep;
    logic             is_line;
    t_job             job_in;
    t_job             r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    // classify and order endpoints, plots keep their point as given
    always_comb begin
        is_line = i_cmd == CMD_LINE;
        adx = (i_x_a > i_x_b) ? i_x_a - i_x_b : i_x_b - i_x_a;
        ady = (i_y_a > i_y_b) ? i_y_a - i_y_b : i_y_b - i_y_a;
        steep = is_line && (ady > adx);
        ax0 = steep ? i_y_a : i_x_a;
        ay0 = steep ? i_x_a : i_y_a;
        ax1 = steep ? i_y_b : i_x_b;
        ay1 = steep ? i_x_b : i_y_b;
        job_in.cmd   = t_cmd'(i_cmd);
        job_in.steep = steep;
        job_in.ink   = i_ink;
        job_in.baddr = i_byte_addr;
        job_in.dy    = steep ? adx : ady;
        if (is_line && (ax0 > ax1)) begin
            job_in.x0    = ax1;
            job_in.y0    = ay1;
            job_in.x1    = ax0;
            job_in.ydown = ay0 < ay1;
        end else begin
            job_in.x0    = ax0;
            job_in.y0    = ay0;
            job_in.x1    = ax1;
            job_in.ydown = !(ay0 < ay1);
        end
    end

    assign o_ready     = r_cnt != 2'd2;
    assign o_job_valid = r_cnt != 2'd0;
    assign o_job       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_q[r_wp] <= job_in;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= !r_wp;
            if (o_job_valid && i_job_ready) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_job_valid && i_job_ready);
        end
    end

endmodule

[rtl/core/rflp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rflp_back
// walks lines, updates the framebuffer memory and returns one byte per command
// ----------------------------------------------------------------------------
module rflp_back #(
    parameter int PANEL_WIDTH  = rflp_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = rflp_pkg::PANEL_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  rflp_pkg::t_job   i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_read_data
);
    import rflp_pkg::*;

    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int MA_W        = $clog2(STORE_BYTES);
    localparam int ERR_W       = CRD_W + 2;

    logic [7:0]       r_mem [STORE_BYTES];
    logic [7:0]       r_rdata, r_out, n_out;
    t_state           r_st, n_st;
    t_job             r_job;
    logic [CRD_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [ERR_W-1:0] r_err, n_err, e1;
    logic [MA_W-1:0]  r_addr, n_addr, r_ca, n_ca;
    logic [7:0]       r_mask, n_mask;
    logic             r_last, n_last;
    logic             r_pink, n_pink;
    logic             we;
    logic [MA_W-1:0]  waddr, raddr;
    logic [7:0]       wdata;
    logic             job_take;

    // pixel mapping of the current point
    logic [CRD_W-1:0] lx, ly;
    logic             on_panel;
    logic [CRD_W+1:0] py;
    logic [MA_W-1:0]  pix_addr;
    logic [7:0]       pix_mask;
    always_comb begin
        lx = r_job.steep ? r_y : r_x;
        ly = r_job.steep ? r_x : r_y;
        py = (CRD_W+2)'(PANEL_HEIGHT - 1) - (CRD_W+2)'(lx);
        on_panel = (32'(ly) < PANEL_WIDTH) && (32'(lx) < PANEL_HEIGHT);
        pix_addr = MA_W'(32'(py[CRD_W:0]) * ROW_BYTES + 32'(ly >> 3));
        pix_mask = 8'h80 >> ly[2:0];
    end

    // memory with registered read
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (job_take) r_job <= i_job;
        r_x    <= n_x;
        r_y    <= n_y;
        r_err  <= n_err;
        r_addr <= n_addr;
        r_ca   <= n_ca;
        r_mask <= n_mask;
        r_last <= n_last;
        r_pink <= n_pink;
        r_out  <= n_out;
    end

    // sequencer
    always_comb begin
        n_st = r_st; n_x = r_x; n_y = r_y; n_err = r_err;
        n_addr = r_addr; n_ca = r_ca; n_mask = r_mask; n_last = r_last;
        n_pink = r_pink; n_out = r_out;
        we = 1'b0; waddr = r_addr; raddr = r_addr; wdata = 8'h00;
        job_take = 1'b0; e1 = '0;
        o_job_ready = 1'b0;
        o_valid = 1'b0;
        case (r_st)
            ST_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    job_take = 1'b1;
                    n_out = 8'h00;
                    n_x = i_job.x0;
                    n_y = i_job.y0;
                    n_ca = '0;
                    n_err = ERR_W'(i_job.x1 - i_job.x0) >>> 1;
                    n_addr = MA_W'(i_job.baddr);
                    case (i_job.cmd)
                        CMD_PLOT: begin
                            n_pink = i_job.ink; n_last = 1'b1; n_st = ST_PIX;
                            n_x = i_job.steep ? i_job.y0 : i_job.x0;
                            n_y = i_job.steep ? i_job.x0 : i_job.y0;
                        end
                        CMD_LINE: begin
                            n_pink = 1'b1;
                            n_last = i_job.x0 == i_job.x1;
                            n_st = ST_PIX;
                        end
                        CMD_CLEAR: n_st = ST_CLR;
                        default: begin
                            n_st = (32'(i_job.baddr) < STORE_BYTES) ? ST_RDATA : ST_OUT;
                        end
                    endcase
                end
            end
            ST_PIX: begin
                n_addr = pix_addr;
                n_mask = pix_mask;
                n_st = on_panel ? ST_RD : ST_WR;
                if (!on_panel) n_mask = 8'h00;
            end
            ST_RD: begin
                n_st = ST_WR;
            end
            ST_WR: begin
                we = r_mask != 8'h00;
                wdata = r_pink ? (r_rdata & ~r_mask) : (r_rdata | r_mask);
                if (r_last || r_job.cmd == CMD_PLOT) begin
                    n_st = ST_OUT;
                end else begin
                    e1 = r_err - ERR_W'(r_job.dy);
                    n_x = r_x + 1'b1;
                    n_last = (r_x + 1'b1) == r_job.x1;
                    if (e1 < 0) begin
                        n_err = e1 + ERR_W'(r_job.x1 - r_job.x0);
                        n_y = r_job.ydown ? r_y - 1'b1 : r_y + 1'b1;
                    end else begin
                        n_err = e1;
                    end
                    n_st = ST_PIX;
                end
            end
            ST_CLR: begin
                we = 1'b1;
                waddr = r_ca;
                wdata = r_job.ink ? 8'h00 : 8'hff;
                n_ca = r_ca + 1'b1;
                if (32'(r_ca) == STORE_BYTES - 1) n_st = ST_OUT;
            end
            ST_RDATA: begin
                n_st = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (r_job.cmd == CMD_READ && 32'(r_job.baddr) < STORE_BYTES)
                    o_valid = 1'b1;
                if (i_ready) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // read byte appears in the cycle after its address is applied
    assign o_read_data = (r_job.cmd == CMD_READ && 32'(r_job.baddr) < STORE_BYTES)
                         ? r_rdata : r_out;

endmodule

[rtl/core/rotated_framebuffer_line_plotter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_framebuffer_line_plotter_unit
// 1 bpp framebuffer with pixel plot, line draw, clear and byte read
// ----------------------------------------------------------------------------
// Commands enter on a valid/ready channel and each returns one byte on the
// output valid/ready channel (the read byte, zero for other commands).
// A front stage orders line endpoints into a two-entry queue, so new
// commands are taken while the back end works or its result is stalled.
// The back end is a sequencer around one byte memory with a registered read:
//   plot  : map the pixel, read, modify and write its byte, then output
//   line  : read-modify-write of each pixel along the major axis
//   clear : one byte per cycle, ROW_BYTES*PANEL_HEIGHT bytes
//   read  : registered memory read, then output
// Memory contents are undefined after reset until a clear; reset only
// empties the queue and returns the sequencer to idle. When the receiver
// holds ready low the result waits and the queue fills, then input ready
// drops.
// ----------------------------------------------------------------------------
module rotated_framebuffer_line_plotter_unit #(
    parameter int PANEL_WIDTH  = rflp_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = rflp_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rflp_pkg::CMD_W-1:0]  i_cmd,
    input  logic [rflp_pkg::CRD_W-1:0]  i_x_a,
    input  logic [rflp_pkg::CRD_W-1:0]  i_y_a,
    input  logic [rflp_pkg::CRD_W-1:0]  i_x_b,
    input  logic [rflp_pkg::CRD_W-1:0]  i_y_b,
    input  logic                        i_ink,
    input  logic [rflp_pkg::ADDR_W-1:0] i_byte_addr,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_read_data
);
    import rflp_pkg::*;

    t_job job;
    logic job_valid, job_ready;

    rflp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_x_a(i_x_a), .i_y_a(i_y_a), .i_x_b(i_x_b), .i_y_b(i_y_b),
        .i_ink(i_ink), .i_byte_addr(i_byte_addr),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    rflp_back #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .o_valid(o_valid), .i_ready(i_ready), .o_read_data(o_read_data)
    );

endmodule
